>>> design/fcom_pkg.sv
// Shared types and constants for the frame centre-of-mass / annular-sum block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fcom_pkg;

    // Field widths
    localparam int PX_W   = 16;   // raw pixel
    localparam int BYTE_W = 8;    // one byte of a pixel
    localparam int ACC_W  = 32;   // dose and annulus sums
    localparam int MOM_W  = 40;   // row / column moments
    localparam int Q_W    = 16;   // centre of mass, 8 fraction bits
    localparam int FRAC_W = 8;    // fraction bits of the centre
    localparam int HALF_W = 9;    // centre position in half pixels
    localparam int RAD_W  = 20;   // squared radius bounds, times four

    // APB side
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SWAP_BYTES  = 3'd0;
    localparam logic [2:0] REG_WIDE_PIXELS = 3'd1;
    localparam logic [2:0] REG_CENTRE_COL  = 3'd2;
    localparam logic [2:0] REG_CENTRE_ROW  = 3'd3;
    localparam logic [2:0] REG_INNER_SQ4   = 3'd4;
    localparam logic [2:0] REG_OUTER_SQ4   = 3'd5;

    // Reset values of the registers
    localparam logic [HALF_W-1:0] CENTRE_RST = 9'd255;
    localparam logic [RAD_W-1:0]  OUTER_RST  = 20'hFFFFF;

    // Quotient saturation value
    localparam logic [Q_W-1:0] Q_SAT = 16'hFFFF;

    typedef struct packed {
        logic [PX_W-1:0] pixel;
        logic            frame_end;
    } t_in_item;

    typedef struct packed {
        logic [Q_W-1:0]   centre_row;
        logic [Q_W-1:0]   centre_col;
        logic [ACC_W-1:0] dose;
        logic [ACC_W-1:0] annular_sum;
    } t_out_item;

    typedef struct packed {
        logic              swap_bytes;
        logic              wide_pixels;
        logic [HALF_W-1:0] centre_col_half;
        logic [HALF_W-1:0] centre_row_half;
        logic [RAD_W-1:0]  inner_radius_sq4;
        logic [RAD_W-1:0]  outer_radius_sq4;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // input request taken this cycle
        logic div_start;    // launch the divider
        logic div_sel_row;  // divider works on the row moment
        logic out_load;     // load output register, clear accumulators
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic a_last;       // first stage holds the frame's last pixel
        logic b_last;       // second stage holds the frame's last pixel
        logic div_done;     // quotient ready
    } t_dp_sts;

endpackage

`default_nettype wire

>>> design/fcom_div.sv
// Serial divider: floor(moment * 256 / dose), saturated to 16 bits, zero for zero dose.
// One quotient bit per cycle; depends on fcom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcom_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [fcom_pkg::MOM_W-1:0] i_moment,
    input  wire logic [fcom_pkg::ACC_W-1:0] i_dose,
    output logic                           o_done,
    output logic [fcom_pkg::Q_W-1:0]       o_quot
);
    import fcom_pkg::*;

    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    logic [ACC_W-1:0] r_rem;
    logic [Q_W-1:0]   r_num;
    logic [Q_W-1:0]   r_q;
    logic [ACC_W-1:0] r_den;
    logic             r_sat;
    logic             r_zero;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [ACC_W:0]   rem2;
    logic             ge;
    logic [ACC_W:0]   diff;
    logic             sat;

    // Quotient would not fit 16 bits when moment >= dose * 256
    assign sat  = i_moment >= {i_dose, {FRAC_W{1'b0}}};
    assign rem2 = {r_rem, r_num[Q_W-1]};
    assign ge   = rem2 >= {1'b0, r_den};
    assign diff = rem2 - {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division; the top 32 bits of moment*256 start below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_moment[MOM_W-1:FRAC_W];
            r_num  <= {i_moment[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
            r_den  <= i_dose;
            r_sat  <= sat;
            r_zero <= (i_dose == '0);
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[ACC_W-1:0] : rem2[ACC_W-1:0];
            r_num <= {r_num[Q_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    always_comb begin
        priority if (r_zero) o_quot = '0;
        else if (r_sat)      o_quot = Q_SAT;
        else                 o_quot = r_q;
    end

endmodule

`default_nettype wire

>>> design/fcom_dp.sv
// Datapath: position counters, two-stage pixel pipeline, accumulators, divider, output payload.
// Depends on fcom_pkg and fcom_div.
`timescale 1ns / 1ps
`default_nettype none

module fcom_dp #(
    parameter int CAM_WIDTH  = 256,
    parameter int CAM_HEIGHT = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fcom_pkg::t_cfg       i_cfg,
    input  wire fcom_pkg::t_in_item   i_in_data,
    input  wire fcom_pkg::t_dp_cmd    i_cmd,
    output fcom_pkg::t_dp_sts         o_sts,
    output fcom_pkg::t_out_item       o_out_data
);
    import fcom_pkg::*;

    localparam int CW     = (CAM_WIDTH  > 2) ? $clog2(CAM_WIDTH)  : 1;
    localparam int RW     = (CAM_HEIGHT > 2) ? $clog2(CAM_HEIGHT) : 1;
    localparam int PRC_W  = PX_W + CW;
    localparam int PRR_W  = PX_W + RW;
    localparam int DIF_W  = HALF_W + 2;
    localparam int DST_W  = RAD_W + 1;
    localparam logic [CW-1:0] COL_LAST = CW'(CAM_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(CAM_HEIGHT - 1);

    // Position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            if (i_in_data.frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_col == COL_LAST) begin
                r_col <= '0;
                r_row <= (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Stage A: pixel format, moment products, squared distances
    logic [PX_W-1:0]         px;
    logic signed [DIF_W-1:0] dc;
    logic signed [DIF_W-1:0] dr;
    logic signed [2*DIF_W-1:0] dc_sq;
    logic signed [2*DIF_W-1:0] dr_sq;

    always_comb begin
        priority if (!i_cfg.wide_pixels)
            px = {{BYTE_W{1'b0}}, i_in_data.pixel[BYTE_W-1:0]};
        else if (i_cfg.swap_bytes)
            px = {i_in_data.pixel[BYTE_W-1:0], i_in_data.pixel[PX_W-1:BYTE_W]};
        else
            px = i_in_data.pixel;
    end

    assign dc    = $signed(DIF_W'({r_col, 1'b0})) - $signed(DIF_W'(i_cfg.centre_col_half));
    assign dr    = $signed(DIF_W'({r_row, 1'b0})) - $signed(DIF_W'(i_cfg.centre_row_half));
    assign dc_sq = dc * dc;
    assign dr_sq = dr * dr;

    logic              r_a_vld;
    logic              r_a_last;
    logic [PX_W-1:0]   r_a_px;
    logic [PRR_W-1:0]  r_a_prow;
    logic [PRC_W-1:0]  r_a_pcol;
    logic [RAD_W-1:0]  r_a_sqc;
    logic [RAD_W-1:0]  r_a_sqr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_a_last <= 1'b0;
        end else begin
            r_a_vld  <= i_cmd.accept;
            r_a_last <= i_cmd.accept & i_in_data.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a_px   <= px;
            r_a_prow <= px * r_row;
            r_a_pcol <= px * r_col;
            r_a_sqc  <= dc_sq[RAD_W-1:0];
            r_a_sqr  <= dr_sq[RAD_W-1:0];
        end
    end

    // Stage B: annulus test and accumulation
    logic [DST_W-1:0] ring_d2;
    logic             in_ring;
    logic             r_b_last;

    assign ring_d2 = DST_W'(r_a_sqc) + DST_W'(r_a_sqr);
    assign in_ring = (ring_d2 > DST_W'(i_cfg.inner_radius_sq4)) &&
                     (ring_d2 <= DST_W'(i_cfg.outer_radius_sq4));

    logic [ACC_W-1:0] r_dose;
    logic [ACC_W-1:0] r_ring;
    logic [MOM_W-1:0] r_mrow;
    logic [MOM_W-1:0] r_mcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_last <= 1'b0;
            r_dose   <= '0;
            r_ring   <= '0;
            r_mrow   <= '0;
            r_mcol   <= '0;
        end else begin
            r_b_last <= r_a_last;
            if (i_cmd.out_load) begin
                r_dose <= '0;
                r_ring <= '0;
                r_mrow <= '0;
                r_mcol <= '0;
            end else if (r_a_vld) begin
                r_dose <= r_dose + ACC_W'(r_a_px);
                r_mrow <= r_mrow + MOM_W'(r_a_prow);
                r_mcol <= r_mcol + MOM_W'(r_a_pcol);
                if (in_ring) r_ring <= r_ring + ACC_W'(r_a_px);
            end
        end
    end

    // Shared divider, row moment first, then column moment
    logic             div_done;
    logic [Q_W-1:0]   div_quot;
    logic [Q_W-1:0]   r_q_row;
    logic [Q_W-1:0]   r_q_col;

    fcom_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_moment (i_cmd.div_sel_row ? r_mrow : r_mcol),
        .i_dose   (r_dose),
        .o_done   (div_done),
        .o_quot   (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            if (i_cmd.div_sel_row) r_q_row <= div_quot;
            else                   r_q_col <= div_quot;
        end
    end

    // Output payload register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.centre_row  <= r_q_row;
            r_out.centre_col  <= r_q_col;
            r_out.dose        <= r_dose;
            r_out.annular_sum <= r_ring;
        end
    end

    assign o_out_data   = r_out;
    assign o_sts.a_last = r_a_last;
    assign o_sts.b_last = r_b_last;
    assign o_sts.div_done = div_done;

endmodule

`default_nettype wire

>>> design/fcom_ctrl.sv
// Controller: input/output handshakes and the frame-end sequence (drain, two divisions, load).
// Depends on fcom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcom_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire fcom_pkg::t_dp_sts i_sts,
    output fcom_pkg::t_dp_cmd      o_cmd
);
    import fcom_pkg::*;

    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_ROW_GO   = 3'd1;
    localparam logic [2:0] ST_ROW_WAIT = 3'd2;
    localparam logic [2:0] ST_COL_GO   = 3'd3;
    localparam logic [2:0] ST_COL_WAIT = 3'd4;
    localparam logic [2:0] ST_LOAD     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       load;

    // No new pixel once the frame's last pixel is in the pipeline
    assign o_in_ready = (r_state == ST_RUN) && !i_sts.a_last && !i_sts.b_last;
    assign load       = (r_state == ST_LOAD) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN:      if (i_sts.b_last) n_state = ST_ROW_GO;
            ST_ROW_GO:   n_state = ST_ROW_WAIT;
            ST_ROW_WAIT: if (i_sts.div_done) n_state = ST_COL_GO;
            ST_COL_GO:   n_state = ST_COL_WAIT;
            ST_COL_WAIT: if (i_sts.div_done) n_state = ST_LOAD;
            ST_LOAD:     if (load) n_state = ST_RUN;
            default:     n_state = ST_RUN;
        endcase
    end

    // Output register valid
    always_comb begin
        priority if (load)       n_out_valid = 1'b1;
        else if (i_out_ready)    n_out_valid = 1'b0;
        else                     n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands
    assign o_cmd.accept      = i_in_valid && o_in_ready;
    assign o_cmd.div_start   = (r_state == ST_ROW_GO) || (r_state == ST_COL_GO);
    assign o_cmd.div_sel_row = (r_state == ST_ROW_GO) || (r_state == ST_ROW_WAIT);
    assign o_cmd.out_load    = load;
    assign o_out_valid       = r_out_valid;

    // Checks
    a_last_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && i_sts.b_last) |=> (r_state == ST_ROW_GO))
        else $error("frame end did not start the division");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out_valid)
        else $error("output load lost");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_cmd.accept)
        else $error("pixel taken during frame-end sequence");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_ROW_WAIT || r_state == ST_COL_WAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

>>> design/frame_center_of_mass_annular_sum.sv
// Top level: APB configuration registers, controller and datapath.
// Depends on fcom_pkg, fcom_ctrl, fcom_dp (and fcom_div through it).
`timescale 1ns / 1ps
`default_nettype none

// Frame centre of mass with annular sum. Pixels of one frame arrive in raster order
// (column fastest) on the input channel; one pixel is taken per cycle while a frame
// streams. The pixel marked frame_end closes the frame: the block then takes no pixel
// while it drains the pipeline, computes two 16-bit quotients in turn in one shared
// divider at one bit per cycle and loads the output register; then one result request
// with centre_row, centre_col (8 fraction bits, 0 for zero dose, saturated at
// 0xFFFF), dose and annular_sum is offered. The output register holds that result
// while the next frame streams in; a second frame end waits at the load step until
// the previous result is taken. Registers sit at byte addresses 4*index on the APB
// port; the user must see they are written only while idle; the block does not check.

module frame_center_of_mass_annular_sum #(
    parameter int CAM_WIDTH  = 256,
    parameter int CAM_HEIGHT = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // pixel input
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire fcom_pkg::t_in_item            i_in_data,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output fcom_pkg::t_out_item                o_out_data,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fcom_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fcom_pkg::APB_DW-1:0]   pwdata,
    output logic [fcom_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import fcom_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swap_bytes       <= 1'b0;
            r_cfg.wide_pixels      <= 1'b1;
            r_cfg.centre_col_half  <= CENTRE_RST;
            r_cfg.centre_row_half  <= CENTRE_RST;
            r_cfg.inner_radius_sq4 <= '0;
            r_cfg.outer_radius_sq4 <= OUTER_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SWAP_BYTES:  r_cfg.swap_bytes       <= pwdata[0];
                REG_WIDE_PIXELS: r_cfg.wide_pixels      <= pwdata[0];
                REG_CENTRE_COL:  r_cfg.centre_col_half  <= pwdata[HALF_W-1:0];
                REG_CENTRE_ROW:  r_cfg.centre_row_half  <= pwdata[HALF_W-1:0];
                REG_INNER_SQ4:   r_cfg.inner_radius_sq4 <= pwdata[RAD_W-1:0];
                REG_OUTER_SQ4:   r_cfg.outer_radius_sq4 <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_SWAP_BYTES:  prdata = APB_DW'(r_cfg.swap_bytes);
            REG_WIDE_PIXELS: prdata = APB_DW'(r_cfg.wide_pixels);
            REG_CENTRE_COL:  prdata = APB_DW'(r_cfg.centre_col_half);
            REG_CENTRE_ROW:  prdata = APB_DW'(r_cfg.centre_row_half);
            REG_INNER_SQ4:   prdata = APB_DW'(r_cfg.inner_radius_sq4);
            REG_OUTER_SQ4:   prdata = APB_DW'(r_cfg.outer_radius_sq4);
            default:         prdata = '0;
        endcase
    end

    t_dp_cmd cmd;
    t_dp_sts sts;

    fcom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fcom_dp #(
        .CAM_WIDTH  (CAM_WIDTH),
        .CAM_HEIGHT (CAM_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/frame_stats_checker.sv
// Checker for frame_center_of_mass_annular_sum: watches the pixel, result and APB channels,
// predicts each frame's result and compares it field by field. Depends on fcom_pkg.
`timescale 1ns / 1ps

module frame_stats_checker #(
    parameter int FRAME_COLS = 256,
    parameter int FRAME_ROWS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  fcom_pkg::t_in_item                  i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  fcom_pkg::t_out_item                 i_out_data,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [fcom_pkg::APB_AW-1:0]         i_paddr,
    input  logic [fcom_pkg::APB_DW-1:0]         i_pwdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_results
);
    import fcom_pkg::*;

    // Shadow registers and frame accumulators
    t_cfg             cfg;
    logic [7:0]       pos_col;
    logic [7:0]       pos_row;
    logic [ACC_W-1:0] dose_sum;
    logic [ACC_W-1:0] ring_sum;
    logic [MOM_W-1:0] row_mom;
    logic [MOM_W-1:0] col_mom;
    t_out_item        frame_results_q[$];
    int               fails;
    int               results;

    // Centre of mass with 8 fraction bits, zero for an empty frame, saturated
    function automatic logic [Q_W-1:0] centroid_q8(input logic [MOM_W-1:0] moment,
                                                   input logic [ACC_W-1:0] dose);
        logic [63:0] q;
        if (dose == '0)
            return '0;
        q = {16'd0, moment, 8'd0} / {32'd0, dose};
        return (q > 64'hFFFF) ? Q_SAT : q[Q_W-1:0];
    endfunction

    // Squared distance along one axis, both terms in half pixels
    function automatic int unsigned axis_dist_sq(input logic [7:0] pos,
                                                 input logic [HALF_W-1:0] centre_half);
        int d;
        d = 2 * int'(pos) - int'(centre_half);
        return d * d;
    endfunction

    function automatic int field_errors(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want === got)
            return 0;
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        case (addr[APB_AW-1:2])
            REG_SWAP_BYTES:  cfg.swap_bytes       = data[0];
            REG_WIDE_PIXELS: cfg.wide_pixels      = data[0];
            REG_CENTRE_COL:  cfg.centre_col_half  = data[HALF_W-1:0];
            REG_CENTRE_ROW:  cfg.centre_row_half  = data[HALF_W-1:0];
            REG_INNER_SQ4:   cfg.inner_radius_sq4 = data[RAD_W-1:0];
            REG_OUTER_SQ4:   cfg.outer_radius_sq4 = data[RAD_W-1:0];
            default: ;
        endcase
    endtask

    // One pixel into the sums; the frame's last pixel yields the expected result
    task automatic take_pixel(input t_in_item item);
        logic [PX_W-1:0] px;
        int unsigned     d;
        t_out_item       res;
        if (cfg.wide_pixels)
            px = cfg.swap_bytes ? {item.pixel[7:0], item.pixel[15:8]} : item.pixel;
        else
            px = {8'h00, item.pixel[7:0]};

        dose_sum = dose_sum + {16'd0, px};
        row_mom  = row_mom + {24'd0, px} * {32'd0, pos_row};
        col_mom  = col_mom + {24'd0, px} * {32'd0, pos_col};

        // inner bound exclusive, outer inclusive
        d = axis_dist_sq(pos_col, cfg.centre_col_half)
            + axis_dist_sq(pos_row, cfg.centre_row_half);
        if (d > cfg.inner_radius_sq4 && d <= cfg.outer_radius_sq4)
            ring_sum = ring_sum + {16'd0, px};

        if (item.frame_end) begin
            res.centre_row  = centroid_q8(row_mom, dose_sum);
            res.centre_col  = centroid_q8(col_mom, dose_sum);
            res.dose        = dose_sum;
            res.annular_sum = ring_sum;
            frame_results_q.insert(frame_results_q.size(), res);
            pos_col  = '0;
            pos_row  = '0;
            dose_sum = '0;
            ring_sum = '0;
            row_mom  = '0;
            col_mom  = '0;
        end else if (int'(pos_col) + 1 >= FRAME_COLS) begin
            // raster wrap; an overlong frame wraps the row too
            pos_col = '0;
            pos_row = (int'(pos_row) + 1 >= FRAME_ROWS) ? 8'd0 : pos_row + 8'd1;
        end else begin
            pos_col = pos_col + 8'd1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cfg.swap_bytes       = 1'b0;
            cfg.wide_pixels      = 1'b1;
            cfg.centre_col_half  = CENTRE_RST;
            cfg.centre_row_half  = CENTRE_RST;
            cfg.inner_radius_sq4 = '0;
            cfg.outer_radius_sq4 = OUTER_RST;
            pos_col  = '0;
            pos_row  = '0;
            dose_sum = '0;
            ring_sum = '0;
            row_mom  = '0;
            col_mom  = '0;
            frame_results_q.delete();
            fails    = 0;
            results  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(i_paddr, i_pwdata);

            // result request: compare against the oldest predicted frame
            if (i_out_valid && i_out_ready) begin
                results++;
                if (frame_results_q.size() == 0) begin
                    $error("result request with no frame outstanding");
                    fails++;
                end else begin
                    want = frame_results_q.pop_front();
                    fails += field_errors("centre_row", want.centre_row, i_out_data.centre_row);
                    fails += field_errors("centre_col", want.centre_col, i_out_data.centre_col);
                    fails += field_errors("dose", want.dose, i_out_data.dose);
                    fails += field_errors("annular_sum", want.annular_sum,
                                          i_out_data.annular_sum);
                end
            end

            if (i_in_valid && i_in_ready)
                take_pixel(i_in_data);
        end
        o_fail_count <= fails;
        o_pending    <= frame_results_q.size();
        o_results    <= results;
    end

endmodule

>>> tb/tb.sv
// Testbench top for frame_center_of_mass_annular_sum: directed frames, then random frames under
// three pacing modes and many register setups. Depends on fcom_pkg and frame_stats_checker.
`timescale 1ns / 1ps

module tb;
    import fcom_pkg::*;

    localparam int COLS          = 256;
    localparam int ROWS          = 256;
    localparam int STALL_LIMIT   = 5000;   // cycles with no request taken
    localparam int HOLD_CYCLES   = 400;    // long output back-pressure
    localparam int SETTLE_CYCLES = 64;     // quiet time after the last result is taken
    localparam int FIRST_PIXELS  = 300;    // first group of a phase opens with a multi-row frame
    localparam int GROUP_PIXELS  = 92;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    t_in_item            in_data    = '0;
    logic                out_ready  = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic                in_ready;
    logic                out_valid;
    t_out_item           out_data;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int fail_count;
    int pending;
    int results;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int pixels_sent   = 0;
    int setups        = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    frame_center_of_mass_annular_sum #(
        .CAM_WIDTH  (COLS),
        .CAM_HEIGHT (ROWS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    frame_stats_checker #(
        .FRAME_COLS (COLS),
        .FRAME_ROWS (ROWS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    // Result side: random back-pressure, plus a long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: no progress on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request taken for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One pixel request, with a random gap ahead of it
    task automatic send_pixel(input logic [PX_W-1:0] px, input logic last);
        t_in_item item;
        item.pixel     = px;
        item.frame_end = last;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    function automatic logic [PX_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            3:       return {8'($urandom_range(255)), 8'h00};
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_frame(input int len, input bit all_zero);
        for (int k = 0; k < len; k++)
            send_pixel(all_zero ? 16'h0000 : pick_pixel(), k == len - 1);
    endtask

    // Wait until every frame result is out and the block has gone quiet
    task automatic quiesce();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; may carry junk above the register width
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value, input int width);
        logic [31:0] junk;
        junk    = ($urandom_range(3) == 0) ? ($urandom << width) : 32'd0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value | junk;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic apply_setup(input bit swap, input bit wide, input logic [HALF_W-1:0] ccol,
                               input logic [HALF_W-1:0] crow, input logic [RAD_W-1:0] inner,
                               input logic [RAD_W-1:0] outer);
        cfg_write(REG_SWAP_BYTES, swap, 1);
        cfg_write(REG_WIDE_PIXELS, wide, 1);
        cfg_write(REG_CENTRE_COL, ccol, HALF_W);
        cfg_write(REG_CENTRE_ROW, crow, HALF_W);
        cfg_write(REG_INNER_SQ4, inner, RAD_W);
        cfg_write(REG_OUTER_SQ4, outer, RAD_W);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        setups++;
    endtask

    // Ring placed mostly over the first rows, where short frames land
    task automatic apply_random_setup();
        logic [HALF_W-1:0] ccol;
        logic [HALF_W-1:0] crow;
        logic [RAD_W-1:0]  inner;
        logic [RAD_W-1:0]  outer;
        ccol  = ($urandom_range(7) == 0) ? 9'd511 : 9'($urandom_range(511));
        crow  = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(8));
        inner = ($urandom_range(3) == 0) ? 20'd0 : 20'($urandom_range(60000));
        case ($urandom_range(5))
            0:       outer = 20'hFFFFF;
            1:       outer = 20'($urandom_range(60000));   // may fall below inner
            default: outer = inner + 20'($urandom_range(90000));
        endcase
        apply_setup($urandom_range(1), $urandom_range(3) != 0, ccol, crow, inner, outer);
    endtask

    initial begin
        int len;
        int sent;
        int budget;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Reset setup: empty frame, then field extremes
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h8001, 1'b0);
        send_pixel(16'h7FFE, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b1);

        // Byte swap; ring edge hits exactly at both bounds
        quiesce();
        apply_setup(1'b1, 1'b1, 9'd0, 9'd0, 20'd0, 20'd4);
        send_pixel(16'h1234, 1'b0);
        send_pixel(16'h00FF, 1'b0);
        send_pixel(16'hFF00, 1'b0);
        send_pixel(16'hA55A, 1'b1);

        // Eight-bit pixels ignore swap; empty ring at register maxima
        quiesce();
        apply_setup(1'b1, 1'b0, 9'd511, 9'd511, 20'hFFFFF, 20'hFFFFF);
        send_pixel(16'hABCD, 1'b0);
        send_pixel(16'hFF80, 1'b0);
        send_pixel(16'h00FF, 1'b1);

        // Narrow ring around column 3
        quiesce();
        apply_setup(1'b0, 1'b1, 9'd6, 9'd0, 20'd3, 20'd9);
        for (int k = 0; k < 8; k++)
            send_pixel(16'($urandom_range(65535)), k == 7);

        // Random frames under three pacing modes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 37; rx_idle_pct <= 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct <= 37; end
                default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
            endcase
            for (int group = 0; group < 4; group++) begin
                quiesce();
                apply_random_setup();
                if (phase == 0 && group == 1)
                    hold_seq <= hold_seq + 1;
                budget = (group == 0) ? FIRST_PIXELS : GROUP_PIXELS;
                sent = 0;
                while (sent < budget) begin
                    // first frame of a phase runs past the end of row 0
                    if (group == 0 && sent == 0)
                        len = $urandom_range(290, 257);
                    else
                        len = ($urandom_range(19) == 0) ? $urandom_range(600, 257)
                                                        : $urandom_range(20, 1);
                    if (len > budget - sent)
                        len = budget - sent;
                    send_frame(len, $urandom_range(12) == 0);
                    sent += len;
                end
            end
        end

        quiesce();
        $display("Run covered %0d pixels, %0d frame results, %0d register setups,",
                 pixels_sent, results, setups);
        $display("three pacing modes, a long result hold and frames spanning several rows.");
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
